[rtl/core/ide_pkg.sv]
// Shared types and constants for the indexed double-ended list.
// Holds command and status codes, stream widths and the cell control struct.
// No dependencies.
`default_nettype none

package ide_pkg;

  localparam int DEFAULT_CAPACITY   = 16;
  localparam int DEFAULT_DATA_WIDTH = 32;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 5;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int READ_W  = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd6;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } ide_shift_t;

endpackage

`default_nettype wire

[rtl/core/ide_cell.sv]
// One storage cell of the list row; it holds the element at a fixed index.
// Depends on ide_pkg for the shift control struct.
`default_nettype none

module ide_cell #(
  parameter int DATA_WIDTH = ide_pkg::DEFAULT_DATA_WIDTH,
  parameter int IDX_W      = 4,
  parameter int INDEX      = 0
) (
  input  wire                       clk,
  input  wire ide_pkg::ide_shift_t  shift,
  input  wire  [IDX_W-1:0]          idx,
  input  wire  [DATA_WIDTH-1:0]     load_data,
  input  wire  [DATA_WIDTH-1:0]     left_data,
  input  wire  [DATA_WIDTH-1:0]     right_data,
  output logic [DATA_WIDTH-1:0]     data
);
  import ide_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;

  always_ff @(posedge clk) begin
    if (shift.ins && (MY_IDX > idx)) begin
      data_r <= left_data;
    end else if (shift.ins && (MY_IDX == idx)) begin
      data_r <= load_data;
    end else if (shift.rem && (MY_IDX >= idx)) begin
      data_r <= right_data;
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

[rtl/core/indexed_double_ended_list.sv]
// Top level of the indexed double-ended list: command decode, count and result register.
// Depends on ide_pkg and instantiates a row of ide_cell.
//
// The block keeps an ordered list of up to CAPACITY words; element 0 is the front.
// Requests arrive on the in_ stream: push front, push back, insert, pop front,
// pop back, erase and read. Each request yields exactly one result on the out_
// stream with a status, the count after the request and, for a good read, the word.
// Inserts and erases move every cell above the index by one place in the same
// cycle, so each request completes when accepted and the result appears in the
// output register on the cycle after acceptance. The block accepts one request
// per cycle; the output register is the only buffer, so while the receiver
// holds out_tready low with a result waiting, in_tready stays low as well.
// Reset empties the list and drops any waiting result; the stored words are
// not cleared, since only elements below the count are ever read.
`default_nettype none

module indexed_double_ended_list #(
  parameter int CAPACITY   = ide_pkg::DEFAULT_CAPACITY,
  parameter int DATA_WIDTH = ide_pkg::DEFAULT_DATA_WIDTH
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // command [2:0], position [7:3], value [39:8]
  input  wire  [ide_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // status [1:0], count [6:2], read_value [38:7], zero [39]
  output logic [ide_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ide_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CMD_W-1:0]   cmd;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] value;
  logic               in_fire;

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r;
  logic [STAT_W-1:0]  status_nxt;
  logic [CNT_W-1:0]   res_count_r;
  logic [READ_W-1:0]  read_r;
  logic [READ_W-1:0]  read_nxt;

  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CNT_W-1:0]   idx_cnt;
  logic [IDX_W-1:0]   idx;
  ide_shift_t         shift;

  logic [DATA_WIDTH+VALUE_W-1:0] value_wide;
  logic [DATA_WIDTH-1:0]         load_data;
  logic [DATA_WIDTH-1:0]         cell_data [CAPACITY];
  logic [DATA_WIDTH+READ_W-1:0]  read_wide;
  logic [CNT_W+COUNT_W-1:0]      count_wide;

  assign cmd   = in_tdata[CMD_W-1:0];
  assign pos   = in_tdata[CMD_W+POS_W-1:CMD_W];
  assign value = in_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign pos_ext = CMP_W'(pos);
  assign cnt_ext = CMP_W'(count_r);

  assign value_wide = {{DATA_WIDTH{1'b0}}, value};
  assign load_data  = value_wide[DATA_WIDTH-1:0];
  assign read_wide  = {{READ_W{1'b0}}, cell_data[pos_ext[IDX_W-1:0]]};

  always_comb begin
    idx_cnt    = '0;
    shift      = '0;
    status_nxt = ST_IGNORED;
    read_nxt   = '0;
    count_nxt  = count_r;
    unique case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (cmd == CMD_PUSH_FRONT) begin
          idx_cnt = '0;
        end else if (cmd == CMD_PUSH_BACK) begin
          idx_cnt = count_r;
        end else begin
          idx_cnt = pos_ext[CNT_W-1:0];
        end
        if ((cmd == CMD_INSERT) && (pos_ext > cnt_ext)) begin
          status_nxt = ST_IGNORED;
        end else if (count_r >= CAP_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          shift.ins  = 1'b1;
          status_nxt = ST_DONE;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
        if (cmd == CMD_POP_FRONT) begin
          idx_cnt = '0;
        end else if (cmd == CMD_POP_BACK) begin
          idx_cnt = count_r - CNT_W'(1);
        end else begin
          idx_cnt = pos_ext[CNT_W-1:0];
        end
        if ((count_r == '0) || ((cmd == CMD_ERASE) && (pos_ext >= cnt_ext))) begin
          status_nxt = ST_IGNORED;
        end else begin
          shift.rem  = 1'b1;
          status_nxt = ST_DONE;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext < cnt_ext) begin
          status_nxt = ST_DONE;
          read_nxt   = read_wide[READ_W-1:0];
        end
      end
      default: begin
        status_nxt = ST_IGNORED;
      end
    endcase
    if (!in_fire) begin
      shift = '0;
    end
  end

  assign idx = idx_cnt[IDX_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end

    ide_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk        (clk),
      .shift      (shift),
      .idx        (idx),
      .load_data  (load_data),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r    <= status_nxt;
      res_count_r <= count_nxt;
      read_r      <= read_nxt;
    end
  end

  assign count_wide = {{COUNT_W{1'b0}}, res_count_r};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, read_r, count_wide[COUNT_W-1:0], status_r};

endmodule

`default_nettype wire
